### rtl/core/smx_pkg.sv
package smx_pkg;

    localparam int unsigned VectorMaxDefault = 64;
    localparam int unsigned ScoreW = 16;
    localparam int unsigned ProbW = 17;
    localparam int unsigned SumW = 23;
    localparam logic [16:0] Log2eQ16 = 17'd94548;
    localparam logic [15:0] ExpCutoff = 16'd4096;
    localparam logic signed [ScoreW-1:0] ScoreMin = 16'sh8000;
    localparam int unsigned DivSteps = 33;

    typedef struct packed {
        logic load;
        logic exp_rd;
        logic exp_mul;
        logic exp_int;
        logic exp_acc;
        logic div_step;
        logic norm_rd;
        logic norm_mul;
        logic out_valid;
        logic out_pop;
    } smx_cmd_t;

    typedef struct packed {
        logic in_fire;
        logic load_close;
        logic idx_last;
        logic div_last;
        logic out_fire;
    } smx_stat_t;

    // 2^(-j/16) in Q1.16, j = 0..16
    function automatic logic [16:0] pow2_frac(input logic [4:0] j);
        logic [16:0] v;
        case (j)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd62757;
            5'd2:  v = 17'd60097;
            5'd3:  v = 17'd57549;
            5'd4:  v = 17'd55109;
            5'd5:  v = 17'd52773;
            5'd6:  v = 17'd50535;
            5'd7:  v = 17'd48393;
            5'd8:  v = 17'd46341;
            5'd9:  v = 17'd44376;
            5'd10: v = 17'd42495;
            5'd11: v = 17'd40693;
            5'd12: v = 17'd38968;
            5'd13: v = 17'd37316;
            5'd14: v = 17'd35734;
            5'd15: v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/smx_score_if.sv
interface smx_score_if;
    import smx_pkg::*;
    logic valid;
    logic ready;
    logic signed [ScoreW-1:0] score;
    logic last_score;

    modport source (output valid, output score, output last_score, input ready);
    modport sink (input valid, input score, input last_score, output ready);
endinterface

### rtl/core/smx_prob_if.sv
interface smx_prob_if;
    import smx_pkg::*;
    logic valid;
    logic ready;
    logic [ProbW-1:0] probability;
    logic last_probability;

    modport source (output valid, output probability, output last_probability, input ready);
    modport sink (input valid, input probability, input last_probability, output ready);
endinterface

### rtl/core/softmax_unit.sv
// channel | dir | fields                          | word
// scores  | in  | score (s16 Q8.8), last_score     | one score
// probs   | out | probability (u17 Q1.16), last_probability | one probability
//
// Scores load at one word per cycle; the word with last_score set, or the
// VECTOR_MAX-th word, closes the vector. Then follow the exponential pass
// (read, multiply, interpolate, accumulate per element), the reciprocal
// divider and the normalize pass (read, multiply, output per element),
// which output stalls hold. Input is held off (ready low) from the closing
// word until the last probability is taken. Reset clears control state only.
module softmax_unit
    import smx_pkg::*;
#(
    parameter int unsigned VECTOR_MAX = VectorMaxDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    smx_score_if.sink   scores,
    smx_prob_if.source  probs
);

    smx_cmd_t  cmd;
    smx_stat_t stat;
    logic      in_ready;

    assign scores.ready = in_ready;
    assign probs.valid = cmd.out_valid;
    assign stat.in_fire = scores.valid && in_ready;
    assign stat.out_fire = cmd.out_valid && probs.ready;

    smx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    smx_dp #(
        .VECTOR_MAX (VECTOR_MAX)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .score            (scores.score),
        .last_score       (scores.last_score),
        .load_close       (stat.load_close),
        .idx_last         (stat.idx_last),
        .div_last         (stat.div_last),
        .probability      (probs.probability),
        .last_probability (probs.last_probability)
    );

endmodule

### rtl/core/smx_ctrl.sv
module smx_ctrl
    import smx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  smx_stat_t stat,
    output logic      in_ready,
    output smx_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_LOAD     = 9'b000000001,
        S_EXP_RD   = 9'b000000010,
        S_EXP_MUL  = 9'b000000100,
        S_EXP_INT  = 9'b000001000,
        S_EXP_ACC  = 9'b000010000,
        S_DIV      = 9'b000100000,
        S_NORM_RD  = 9'b001000000,
        S_NORM_MUL = 9'b010000000,
        S_NORM_OUT = 9'b100000000
    } smx_state_t;

    smx_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = stat.in_fire;
                if (stat.in_fire && stat.load_close)
                begin
                    state_next = S_EXP_RD;
                end
            end
            S_EXP_RD:
            begin
                cmd.exp_rd = 1'b1;
                state_next = S_EXP_MUL;
            end
            S_EXP_MUL:
            begin
                cmd.exp_mul = 1'b1;
                state_next = S_EXP_INT;
            end
            S_EXP_INT:
            begin
                cmd.exp_int = 1'b1;
                state_next = S_EXP_ACC;
            end
            S_EXP_ACC:
            begin
                cmd.exp_acc = 1'b1;
                state_next = stat.idx_last ? S_DIV : S_EXP_RD;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_NORM_RD;
                end
            end
            S_NORM_RD:
            begin
                cmd.norm_rd = 1'b1;
                state_next = S_NORM_MUL;
            end
            S_NORM_MUL:
            begin
                cmd.norm_mul = 1'b1;
                state_next = S_NORM_OUT;
            end
            S_NORM_OUT:
            begin
                cmd.out_valid = 1'b1;
                cmd.out_pop = stat.out_fire;
                if (stat.out_fire)
                begin
                    state_next = stat.idx_last ? S_LOAD : S_NORM_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

### rtl/core/smx_dp.sv
module smx_dp
    import smx_pkg::*;
#(
    parameter int unsigned VECTOR_MAX = VectorMaxDefault
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  smx_cmd_t                 cmd,
    input  logic signed [ScoreW-1:0] score,
    input  logic                     last_score,
    output logic                     load_close,
    output logic                     idx_last,
    output logic                     div_last,
    output logic [ProbW-1:0]         probability,
    output logic                     last_probability
);

    localparam int unsigned CntW = $clog2(VECTOR_MAX + 1);
    localparam int unsigned IdxW = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1;
    localparam int unsigned DcntW = $clog2(DivSteps + 1);

    logic signed [ScoreW-1:0] score_mem [VECTOR_MAX];
    logic [ProbW-1:0]         exp_mem [VECTOR_MAX];

    logic [CntW-1:0]          count_reg;
    logic signed [ScoreW-1:0] max_reg;
    logic [IdxW-1:0]          idx_reg;
    logic [SumW-1:0]          sum_reg;
    logic signed [ScoreW-1:0] srd_reg;
    logic [17:0]              y_reg;
    logic                     cut_reg;
    logic [ProbW-1:0]         e_reg;
    logic [SumW:0]            rem_reg;
    logic [ProbW-1:0]         q_reg;
    logic [DcntW-1:0]         dcnt_reg;
    logic [ProbW-1:0]         erd_reg;
    logic [ProbW-1:0]         p_reg;

    logic [16:0] diff_s;
    logic [15:0] t;
    logic [33:0] y_full;
    logic [9:0]  k;
    logic [3:0]  j;
    logic [3:0]  r;
    logic [16:0] t_lo;
    logic [16:0] t_hi;
    logic [15:0] interp;
    logic [16:0] m;
    logic [ProbW-1:0] e_next;
    logic [SumW:0] rem_sh;
    logic          ge;
    logic [ProbW-1:0] inv;
    logic [33:0] p_full;

    assign load_close = last_score || (count_reg == CntW'(VECTOR_MAX - 1));
    assign idx_last = (idx_reg == IdxW'(count_reg - 1'b1));
    assign div_last = (dcnt_reg == DcntW'(1));
    assign probability = p_reg;
    assign last_probability = idx_last;

    // exponential: t*log2(e) in Q8.8, then table interpolation and shift
    always_comb
    begin
        diff_s = 17'(max_reg) - 17'(srd_reg);
        t = diff_s[15:0];
        y_full = 34'(t) * 34'(Log2eQ16) + 34'd32768;
        k = y_reg[17:8];
        j = y_reg[7:4];
        r = y_reg[3:0];
        t_lo = pow2_frac({1'b0, j});
        t_hi = pow2_frac(5'({1'b0, j}) + 5'd1);
        interp = 16'((16'(t_lo - t_hi) * 16'(r) + 16'd8) >> 4);
        m = t_lo - 17'(interp);
        if (cut_reg || (k >= 10'd31))
        begin
            e_next = '0;
        end
        else
        begin
            e_next = m >> k;
        end
    end

    // restoring divide of 2^32 by the sum, one quotient bit per step
    always_comb
    begin
        rem_sh = {rem_reg[SumW-1:0], (dcnt_reg == DcntW'(DivSteps))};
        ge = (rem_sh >= {1'b0, sum_reg});
        inv = (sum_reg == '0) ? '0 : q_reg;
        p_full = 34'(erd_reg) * 34'(inv) + 34'd32768;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            score_mem[count_reg[IdxW-1:0]] <= score;
        end
        if (cmd.exp_acc)
        begin
            exp_mem[idx_reg] <= e_reg;
        end
        if (cmd.exp_rd)
        begin
            srd_reg <= score_mem[idx_reg];
        end
        if (cmd.norm_rd)
        begin
            erd_reg <= exp_mem[idx_reg];
        end
        if (cmd.exp_mul)
        begin
            y_reg <= y_full[33:16];
            cut_reg <= (t > ExpCutoff);
        end
        if (cmd.exp_int)
        begin
            e_reg <= e_next;
        end
        if (cmd.norm_mul)
        begin
            p_reg <= p_full[32:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg <= ScoreMin;
            idx_reg <= '0;
            sum_reg <= '0;
            rem_reg <= '0;
            q_reg <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                count_reg <= count_reg + 1'b1;
                if (score > max_reg)
                begin
                    max_reg <= score;
                end
            end
            if (cmd.exp_acc)
            begin
                sum_reg <= sum_reg + SumW'(e_reg);
                if (idx_last)
                begin
                    idx_reg <= '0;
                    rem_reg <= '0;
                    q_reg <= '0;
                    dcnt_reg <= DcntW'(DivSteps);
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.div_step)
            begin
                rem_reg <= ge ? (rem_sh - {1'b0, sum_reg}) : rem_sh;
                q_reg <= {q_reg[ProbW-2:0], ge};
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            if (cmd.out_pop)
            begin
                if (idx_last)
                begin
                    idx_reg <= '0;
                    count_reg <= '0;
                    max_reg <= ScoreMin;
                    sum_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

endmodule

### dv/softmax_checker.sv
`timescale 1ns / 100ps

module softmax_checker
    import smx_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    smx_score_if  scores,
    smx_prob_if   probs,
    output int    fails,
    output int    pending
);

    localparam int unsigned VectorMax = VectorMaxDefault;

    typedef struct packed {
        logic [ProbW-1:0] probability;
        logic             last_probability;
    } prob_word_t;

    // 2^(-j/16) in Q1.16
    localparam logic [16:0] Pow2Tab [0:16] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    logic signed [ScoreW-1:0] vec_scores [VectorMax];
    logic signed [ScoreW-1:0] vec_max;
    int unsigned              vec_len;
    prob_word_t               prob_expect [$];

    function automatic logic [16:0] exp_of_diff(logic signed [ScoreW-1:0] s,
                                                logic signed [ScoreW-1:0] mx);
        int unsigned     t, y, k, f, j, r;
        logic [16:0]     m;
        if (s >= mx)
            return 17'd65536;
        t = int'(mx) - int'(s);
        if (t > 4096)
            return 17'd0;
        y = int'((longint'(t) * 94548 + 32768) >>> 16);
        k = y >> 8;
        f = y & 255;
        j = f >> 4;
        r = f & 15;
        m = Pow2Tab[j] - 17'(((Pow2Tab[j] - Pow2Tab[j + 1]) * r + 8) >> 4);
        return m >> k;
    endfunction

    // Close the vector: push one expected probability per stored score
    task automatic normalize_vector();
        logic [16:0]         e [VectorMax];
        logic [SumW-1:0]     total;
        longint unsigned     inv, p;
        prob_word_t          w;
        total = '0;
        for (int i = 0; i < vec_len; i++) begin
            e[i] = exp_of_diff(vec_scores[i], vec_max);
            total = total + SumW'(e[i]);
        end
        inv = (total != 0) ? (64'd1 << 32) / total : 0;
        for (int i = 0; i < vec_len; i++) begin
            p = (longint'(e[i]) * inv + 32768) >> 16;
            w.probability = p[ProbW-1:0];
            w.last_probability = (i + 1 == vec_len);
            prob_expect.push_back(w);
        end
        vec_len = 0;
        vec_max = ScoreMin;
    endtask

    always @(posedge clk or negedge rst_n) begin
        prob_word_t want;
        if (!rst_n) begin
            vec_len = 0;
            vec_max = ScoreMin;
            fails = 0;
            prob_expect.delete();
        end else begin
            if (scores.valid && scores.ready) begin
                vec_scores[vec_len] = scores.score;
                vec_len++;
                if (scores.score > vec_max)
                    vec_max = scores.score;
                if (scores.last_score || vec_len >= VectorMax)
                    normalize_vector();
            end
            if (probs.valid && probs.ready) begin
                if (prob_expect.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected probability word %0d last %0b",
                                 probs.probability, probs.last_probability);
                end else begin
                    want = prob_expect.pop_front();
                    if (want.probability !== probs.probability ||
                        want.last_probability !== probs.last_probability) begin
                        fails++;
                        if (fails <= 10)
                            $display("probability exp %0d/%0b got %0d/%0b",
                                     want.probability, want.last_probability,
                                     probs.probability, probs.last_probability);
                    end
                end
            end
        end
        pending = prob_expect.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int StallLimit = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fails;
    int   pending;
    int   idle_pct = 0;
    int   stall_pct = 0;
    logic hold_probs = 1'b0;
    int   items = 0;
    int   quiet_cycles = 0;

    smx_score_if scores();
    smx_prob_if  probs();

    softmax_unit dut (.clk(clk), .rst_n(rst_n), .scores(scores), .probs(probs));

    softmax_checker chk (.clk(clk), .rst_n(rst_n), .scores(scores), .probs(probs),
                         .fails(fails), .pending(pending));

    always #5 clk = ~clk;

    always @(posedge clk)
        probs.ready <= !hold_probs && ($urandom_range(99) >= stall_pct);

    always @(posedge clk) begin
        if ((scores.valid && scores.ready) || (probs.valid && probs.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > StallLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_score(int s, bit last);
        while ($urandom_range(99) < idle_pct) begin
            scores.valid <= 1'b0;
            @(posedge clk);
        end
        scores.valid <= 1'b1;
        scores.score <= 16'(s);
        scores.last_score <= last;
        @(posedge clk);
        while (!scores.ready)
            @(posedge clk);
        items++;
    endtask

    function automatic int clamp_score(int v);
        return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    endfunction

    task automatic send_vector(int len, bit close_last, bit wide);
        int base;
        base = $urandom_range(65535) - 32768;
        for (int i = 0; i < len; i++) begin
            if (wide)
                send_score($urandom_range(65535) - 32768, close_last && i == len - 1);
            else
                send_score(clamp_score(base + int'($urandom_range(3000)) - 1500),
                           close_last && i == len - 1);
        end
    endtask

    task automatic drain();
        scores.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_phase(int quota);
        int goal;
        goal = items + quota;
        while (items < goal) begin
            case ($urandom_range(11))
                0: send_vector(64, 1'b0, $urandom_range(1));   // forced close at the cap
                1: send_vector(64, 1'b1, 1'b0);
                2, 3: send_vector($urandom_range(10, 1), 1'b1, 1'b1);
                default: send_vector($urandom_range(10, 1), 1'b1, 1'b0);
            endcase
        end
        drain();
    endtask

    initial begin
        scores.valid <= 1'b0;
        scores.score <= '0;
        scores.last_score <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single element, full-range extremes, equal scores, cutoff edges
        send_score(0, 1'b1);
        send_score(32767, 1'b0);
        send_score(-32768, 1'b1);
        send_score(100, 1'b0);
        send_score(100, 1'b0);
        send_score(100, 1'b1);
        send_score(0, 1'b0);
        send_score(-4096, 1'b0);
        send_score(-4097, 1'b0);
        send_score(-4095, 1'b1);
        send_score(-32768, 1'b1);
        send_score(256, 1'b0);
        send_score(-256, 1'b0);
        send_score(1, 1'b0);
        send_score(-1, 1'b1);
        send_score(32767, 1'b0);
        send_score(32766, 1'b0);
        send_score(32512, 1'b1);
        drain();

        // hold the output off while scores keep coming, so input backs up
        fork
        begin
            hold_probs <= 1'b1;
            repeat (400) @(posedge clk);
            hold_probs <= 1'b0;
        end
        join_none
        random_phase(90);

        idle_pct = 60;
        random_phase(90);
        idle_pct = 0;
        stall_pct = 60;
        random_phase(90);
        idle_pct = 19;
        stall_pct = 19;
        random_phase(90);

        if (fails == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
